>>> src/pte_pkg.sv
// Shared types, constants and the tag type lookup for the PPPoE tag extractor.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pte_pkg;

  localparam int SLOT_COUNT      = 10;
  localparam int MAX_FRAME_BYTES = 1500;
  localparam int AREA_MAX        = MAX_FRAME_BYTES - 6;
  localparam int KNOWN_TYPES     = 10;

  localparam int SLOT_W  = 4;
  localparam int POS_W   = 11;
  localparam int FIELD_W = 16;
  localparam int BANKS   = 2;
  localparam int MEM_DEPTH = BANKS * (1 << SLOT_W);

  // Known tag types in slot order.
  localparam logic [FIELD_W-1:0] KNOWN_TYPE [KNOWN_TYPES] = '{
    16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0105,
    16'h0110, 16'h0201, 16'h0202, 16'h0203, 16'h0000
  };

  typedef logic [SLOT_W-1:0]     slot_idx_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [SLOT_COUNT-1:0] slot_mask_t;

  // Which byte of the four-byte tag header comes next.
  typedef enum logic [1:0] {
    HDR_TYPE_HI,
    HDR_TYPE_LO,
    HDR_LEN_HI,
    HDR_LEN_LO
  } hdr_phase_t;

  typedef struct packed {
    logic      hit;
    slot_idx_t slot;
  } type_match_t;

  // One stored record per slot.
  typedef struct packed {
    pos_t offset;
    pos_t length;
  } slot_rec_t;

  // Write of a newly completed tag into the slot memory.
  typedef struct packed {
    logic      en;
    slot_idx_t slot;
    slot_rec_t rec;
  } rec_write_t;

  // Raised on the accepted last byte, with the frame's found bits.
  typedef struct packed {
    logic       done;
    slot_mask_t found;
  } frame_done_t;

  function automatic type_match_t match_type(input logic [FIELD_W-1:0] hdr_code);
    type_match_t m;
    m = '0;
    for (int i = 0; i < KNOWN_TYPES; i++) begin
      if (i < SLOT_COUNT && KNOWN_TYPE[i] == hdr_code) begin
        m.hit  = 1'b1;
        m.slot = SLOT_W'(i);
      end
    end
    return m;
  endfunction

endpackage

>>> src/pte_ifs.sv
// Valid/ready channel interfaces for the tag byte input and the slot results.
// Depends on pte_pkg for field widths.
`timescale 1ns / 1ps

interface pte_in_if;
  import pte_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic       first_byte;
  logic       last_byte;
  pos_t       area_length;

  modport source (output valid, tag_byte, first_byte, last_byte, area_length,
                  input ready);
  modport sink   (input valid, tag_byte, first_byte, last_byte, area_length,
                  output ready);
endinterface

interface pte_out_if;
  import pte_pkg::*;
  logic      valid;
  logic      ready;
  slot_idx_t slot;
  logic      found;
  pos_t      tag_offset;
  pos_t      value_length;
  logic      final_result;

  modport source (output valid, slot, found, tag_offset, value_length, final_result,
                  input ready);
  modport sink   (input valid, slot, found, tag_offset, value_length, final_result,
                  output ready);
endinterface

>>> src/pte_tlv_walker.sv
// Per-byte TLV header walker: tracks position, header phase and value bytes,
// and issues slot memory writes for completed known tags. Depends on pte_pkg.
`timescale 1ns / 1ps

module pte_tlv_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           tag_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  pte_pkg::pos_t        area_length,
  output pte_pkg::rec_write_t  rec_wr,
  output pte_pkg::frame_done_t frame_done
);
  import pte_pkg::*;

  pos_t               pos_r, pos_nxt, pos_e;
  pos_t               end_r, end_nxt, end_e;
  hdr_phase_t         hdr_r, hdr_nxt, hdr_e;
  logic [FIELD_W-1:0] type_r, type_nxt, type_e;
  logic [FIELD_W-1:0] len_r, len_nxt, len_e;
  pos_t               start_r, start_nxt, start_e;
  pos_t               rem_r, rem_nxt, rem_e;
  logic               stop_r, stop_nxt, stop_e;
  slot_mask_t         found_r, found_nxt, found_e;

  logic               record;
  type_match_t        match;
  logic [FIELD_W-1:0] len_full;
  logic [FIELD_W:0]   tag_end;

  always_comb begin
    // A first byte starts from a cleared frame.
    pos_e   = first_byte ? '0 : pos_r;
    end_e   = first_byte ? ((area_length > POS_W'(AREA_MAX)) ? POS_W'(AREA_MAX) : area_length)
                         : end_r;
    hdr_e   = first_byte ? HDR_TYPE_HI : hdr_r;
    type_e  = first_byte ? '0 : type_r;
    len_e   = first_byte ? '0 : len_r;
    start_e = first_byte ? '0 : start_r;
    rem_e   = first_byte ? '0 : rem_r;
    stop_e  = first_byte ? 1'b0 : stop_r;
    found_e = first_byte ? '0 : found_r;

    pos_nxt   = pos_e;
    end_nxt   = end_e;
    hdr_nxt   = hdr_e;
    type_nxt  = type_e;
    len_nxt   = len_e;
    start_nxt = start_e;
    rem_nxt   = rem_e;
    stop_nxt  = stop_e;
    found_nxt = found_e;
    record    = 1'b0;
    len_full  = {len_e[FIELD_W-1:8], tag_byte};
    tag_end   = {{(FIELD_W+1-POS_W){1'b0}}, pos_e} + (FIELD_W+1)'(1) + {1'b0, len_full};

    if (!stop_e && pos_e < end_e) begin
      if (rem_e != '0) begin
        rem_nxt = rem_e - POS_W'(1);
        record  = (rem_e == POS_W'(1));
      end else begin
        case (hdr_e)
          HDR_TYPE_HI: begin
            start_nxt = pos_e;
            type_nxt  = {tag_byte, 8'h00};
            hdr_nxt   = HDR_TYPE_LO;
          end
          HDR_TYPE_LO: begin
            type_nxt = {type_e[FIELD_W-1:8], tag_byte};
            hdr_nxt  = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            len_nxt = {tag_byte, 8'h00};
            hdr_nxt = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            len_nxt = len_full;
            hdr_nxt = HDR_TYPE_HI;
            if (tag_end > {{(FIELD_W+1-POS_W){1'b0}}, end_e}) begin
              stop_nxt = 1'b1;
            end else if (len_full == '0) begin
              record = 1'b1;
            end else begin
              rem_nxt = len_full[POS_W-1:0];
            end
          end
          default: begin
            hdr_nxt = HDR_TYPE_HI;
          end
        endcase
      end
      pos_nxt = pos_e + POS_W'(1);
    end

    // Only the first complete occurrence of a known type is kept.
    match      = match_type(type_nxt);
    rec_wr     = '0;
    rec_wr.slot       = match.slot;
    rec_wr.rec.offset = start_nxt;
    rec_wr.rec.length = len_nxt[POS_W-1:0];
    if (accept && record && match.hit && !found_e[match.slot]) begin
      rec_wr.en                = 1'b1;
      found_nxt[match.slot]    = 1'b1;
    end

    frame_done.done  = accept && last_byte;
    frame_done.found = found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r   <= '0;
      end_r   <= '0;
      hdr_r   <= HDR_TYPE_HI;
      type_r  <= '0;
      len_r   <= '0;
      start_r <= '0;
      rem_r   <= '0;
      stop_r  <= 1'b0;
      found_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
      hdr_r   <= hdr_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      rem_r   <= rem_nxt;
      stop_r  <= stop_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

>>> src/pppoe_tag_extractor_core.sv
// Top level of the PPPoE discovery tag extractor: byte walker, banked slot
// memory and result sequencer. Depends on pte_pkg, pte_ifs and pte_tlv_walker.
`timescale 1ns / 1ps

// The block takes the tag area of a PPPoE discovery frame one byte per cycle,
// save for the last-byte stall below, and on the frame's last byte reports
// one result per known tag slot (ten slots, in the fixed slot order of the
// known types), each giving whether a complete tag of that type was seen, its
// header offset in the area and its value length. Every byte is one transfer
// on the input channel. The ten results of a frame leave on the output
// channel at one per cycle while the output side keeps up; the first is
// offered once readout has started (emit_active_r) and the output register
// has been loaded together with the memory's registered read data.
// Slot records live in a two-bank synchronous memory: one bank fills with
// the frame being walked while the other is read out for the previous
// frame, so bytes of the next frame keep flowing during readout. The only
// stall is on a last byte that arrives before all ten results of the
// previous frame have been issued into the output register; a frame of at
// least eleven bytes therefore never stalls when the output side keeps up.
// No clearing pass is needed after reset.
module pppoe_tag_extractor_core (
  input logic      clk,
  input logic      rst_n,
  pte_in_if.sink   in_ch,
  pte_out_if.source out_ch
);
  import pte_pkg::*;

  localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic        in_accept;
  rec_write_t  rec_wr;
  frame_done_t frame_done;

  // Write bank for the frame being walked and the readout side's state.
  logic        bank_r, bank_nxt;
  logic        emit_active_r, emit_active_nxt;
  logic        emit_bank_r, emit_bank_nxt;
  slot_idx_t   emit_idx_r, emit_idx_nxt;
  slot_mask_t  emit_found_r, emit_found_nxt;

  // Output register; the record half is the memory's registered read data.
  logic        out_valid_r, out_valid_nxt;
  slot_idx_t   out_slot_r;
  logic        out_found_r;
  logic        out_final_r;
  slot_rec_t   rd_rec_r;

  slot_rec_t   slot_mem [MEM_DEPTH];

  logic        advance;
  logic        issue;

  // A last byte needs the readout side free; other bytes never wait.
  assign in_ch.ready = !(emit_active_r && in_ch.last_byte);
  assign in_accept   = in_ch.valid && in_ch.ready;

  pte_tlv_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .tag_byte    (in_ch.tag_byte),
    .first_byte  (in_ch.first_byte),
    .last_byte   (in_ch.last_byte),
    .area_length (in_ch.area_length),
    .rec_wr      (rec_wr),
    .frame_done  (frame_done)
  );

  // The output register moves when it is empty or its transfer completes.
  assign advance = !out_valid_r || out_ch.ready;
  assign issue   = emit_active_r && advance;

  always_comb begin
    bank_nxt        = bank_r;
    emit_active_nxt = emit_active_r;
    emit_bank_nxt   = emit_bank_r;
    emit_idx_nxt    = emit_idx_r;
    emit_found_nxt  = emit_found_r;
    out_valid_nxt   = out_valid_r;

    if (frame_done.done) begin
      // Hand the filled bank to readout and walk the next frame in the other.
      bank_nxt        = !bank_r;
      emit_bank_nxt   = bank_r;
      emit_found_nxt  = frame_done.found;
      emit_idx_nxt    = '0;
      emit_active_nxt = 1'b1;
    end else if (issue) begin
      emit_idx_nxt = emit_idx_r + SLOT_W'(1);
      if (emit_idx_r == LAST_SLOT) begin
        emit_active_nxt = 1'b0;
      end
    end

    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r        <= 1'b0;
      emit_active_r <= 1'b0;
      emit_bank_r   <= 1'b0;
      emit_idx_r    <= '0;
      emit_found_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bank_r        <= bank_nxt;
      emit_active_r <= emit_active_nxt;
      emit_bank_r   <= emit_bank_nxt;
      emit_idx_r    <= emit_idx_nxt;
      emit_found_r  <= emit_found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Slot memory: one write port for the walker, one enabled read port for
  // readout. The two always touch different banks.
  always_ff @(posedge clk) begin
    if (rec_wr.en) begin
      slot_mem[{bank_r, rec_wr.slot}] <= rec_wr.rec;
    end
    if (issue) begin
      rd_rec_r <= slot_mem[{emit_bank_r, emit_idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_slot_r  <= emit_idx_r;
      out_found_r <= emit_found_r[emit_idx_r];
      out_final_r <= (emit_idx_r == LAST_SLOT);
    end
  end

  // A slot that was not found reports zero offset and length.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.tag_offset   = out_found_r ? rd_rec_r.offset : '0;
  assign out_ch.value_length = out_found_r ? rd_rec_r.length : '0;
  assign out_ch.final_result = out_final_r;

`ifndef SYNTHESIS
  // The walker must never write the bank that readout is still reading.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    rec_wr.en && emit_active_r |-> bank_r != emit_bank_r)
    else $error("slot memory write hit the bank under readout");

  // A new frame hand-off only happens with readout idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done.done |-> !emit_active_r)
    else $error("frame finished while previous results still pending");

  // The final flag marks exactly the highest slot.
  a_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_final_r == (out_slot_r == LAST_SLOT)))
    else $error("final_result not on the last slot");

  // Readout starts at slot zero right after a frame ends.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done.done |=> emit_active_r && emit_idx_r == '0)
    else $error("readout did not start at slot zero");
`endif

endmodule
